/* rtl/frgr_pkg.sv */
// Shared types and constants for the fragment reassembly gap requester.
`default_nettype none

package frgr_pkg;

    localparam int MAX_FRAGMENTS = 64;
    localparam int MAP_W         = MAX_FRAGMENTS;
    localparam int IDX_W         = 6;
    localparam int CNT_W         = 7;
    localparam int PKT_W         = 16;
    localparam int STATUS_W      = 2;
    localparam int JOBQ_DEPTH    = 2;
    localparam int JOBQ_PTR_W    = $clog2(JOBQ_DEPTH);
    localparam int JOBQ_CNT_W    = $clog2(JOBQ_DEPTH + 1);

    localparam logic OP_BEGIN  = 1'b0;
    localparam logic OP_ARRIVE = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_READY   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_LOADING = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_ERROR   = 2'd2;

    typedef enum logic {
        JOB_SCAN  = 1'b0,
        JOB_ERROR = 1'b1
    } job_kind_t;

    typedef struct packed {
        job_kind_t          kind;
        logic [MAP_W-1:0]   map;
        logic [CNT_W-1:0]   total;
        logic [PKT_W-1:0]   packet;
    } job_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                req_valid;
        logic [IDX_W-1:0]    req_index;
        logic [PKT_W-1:0]    packet;
        logic                last;
    } result_t;

endpackage

`default_nettype wire

/* rtl/frgr_front.sv */
// Front end: accepts requests, keeps the packet state and issues scan and error jobs.
`default_nettype none

module frgr_front
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  wire logic                  q_full,
    input  wire logic                  opcode,
    input  wire logic [15:0]           packet_tag,
    input  wire logic [6:0]            fragment_count,
    input  wire logic [5:0]            fragment_index,
    output logic                       job_push,
    output frgr_pkg::job_t             job
);
    import frgr_pkg::*;

    logic [MAP_W-1:0] map_reg,    map_next;
    logic [CNT_W-1:0] total_reg,  total_next;
    logic [PKT_W-1:0] packet_reg, packet_next;
    logic             accept;
    logic             out_of_range;
    logic [CNT_W-1:0] count_sat;
    logic [MAP_W-1:0] map_marked;

    assign accept       = push && !q_full;
    assign out_of_range = {1'b0, fragment_index} >= total_reg;
    assign count_sat    = (fragment_count > CNT_W'(MAX_FRAGMENTS))
                        ? CNT_W'(MAX_FRAGMENTS) : fragment_count;
    assign map_marked   = map_reg | (MAP_W'(1) << fragment_index);

    always_comb
    begin
        map_next    = map_reg;
        total_next  = total_reg;
        packet_next = packet_reg;
        job_push    = 1'b0;
        job.kind    = JOB_SCAN;
        job.map     = map_marked;
        job.total   = total_reg;
        job.packet  = packet_reg;
        if (accept)
        begin
            unique case (opcode)
                OP_BEGIN:
                begin
                    map_next    = '0;
                    total_next  = count_sat;
                    packet_next = packet_tag;
                end
                OP_ARRIVE:
                begin
                    job_push = 1'b1;
                    if (out_of_range)
                    begin
                        job.kind = JOB_ERROR;
                        job.map  = map_reg;
                    end
                    else
                    begin
                        map_next = map_marked;
                    end
                end
                default:
                begin
                    map_next = map_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_reg    <= '0;
            total_reg  <= CNT_W'(1);
            packet_reg <= '0;
        end
        else
        begin
            map_reg    <= map_next;
            total_reg  <= total_next;
            packet_reg <= packet_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/frgr_job_queue.sv */
// Short queue of scan and error jobs between the front end and the scanner.
`default_nettype none

module frgr_job_queue
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  wire frgr_pkg::job_t        job_in,
    output logic                       full,
    input  wire logic                  pop,
    output logic                       job_valid,
    output frgr_pkg::job_t             job_out
);
    import frgr_pkg::*;

    job_t                  mem [JOBQ_DEPTH];
    logic [JOBQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [JOBQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [JOBQ_CNT_W-1:0] count_reg,  count_next;
    logic                  do_push;
    logic                  do_pop;

    assign full      = count_reg == JOBQ_CNT_W'(JOBQ_DEPTH);
    assign job_valid = count_reg != '0;
    assign job_out   = mem[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && job_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == JOBQ_PTR_W'(JOBQ_DEPTH - 1)) ? '0
                        : wr_ptr_reg + JOBQ_PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == JOBQ_PTR_W'(JOBQ_DEPTH - 1)) ? '0
                        : rd_ptr_reg + JOBQ_PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + JOBQ_CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - JOBQ_CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= job_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/frgr_scan.sv */
// Back end: emits a job's results, walking one index per cycle unless stalled.
`default_nettype none

module frgr_scan
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  job_valid,
    input  wire frgr_pkg::job_t        job,
    output logic                       job_pop,
    input  wire logic                  pop,
    output logic                       empty,
    output frgr_pkg::result_t          result
);
    import frgr_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    state_t           state_reg;
    logic [IDX_W-1:0] pos_reg;
    logic             seen_reg;
    logic             missing_reg;
    logic             emitted_reg;
    logic             out_valid_reg;
    result_t          out_reg;

    logic             can_emit;
    logic             bit_rx;
    logic             at_end;
    logic             do_req;
    logic             emit;
    logic             below_full;
    logic             load_out;
    result_t          res;

    assign can_emit   = !out_valid_reg || pop;
    assign bit_rx     = job.map[pos_reg];
    assign at_end     = pos_reg == '0;
    assign do_req     = !bit_rx && (seen_reg || at_end);
    assign emit       = do_req || (at_end && !emitted_reg);
    // every index below this one already received: no further request follows
    assign below_full = &(job.map | ({MAP_W{1'b1}} << pos_reg));
    assign load_out   = (state_reg == ST_IDLE)
                      ? (job_valid && job.kind == JOB_ERROR && can_emit)
                      : (emit && can_emit);

    always_comb
    begin
        res.packet = job.packet;
        if (do_req)
        begin
            res.status    = STATUS_LOADING;
            res.req_valid = 1'b1;
            res.req_index = pos_reg;
            res.last      = at_end || below_full;
        end
        else
        begin
            res.status    = missing_reg ? STATUS_LOADING : STATUS_READY;
            res.req_valid = 1'b0;
            res.req_index = '0;
            res.last      = 1'b1;
        end
    end

    always_comb
    begin
        job_pop = 1'b0;
        unique case (state_reg)
            ST_IDLE: job_pop = job_valid && job.kind == JOB_ERROR && can_emit;
            ST_SCAN: job_pop = at_end && (!emit || can_emit);
            default: job_pop = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            seen_reg      <= 1'b0;
            missing_reg   <= 1'b0;
            emitted_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop && out_valid_reg)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (job_valid)
                    begin
                        if (job.kind == JOB_ERROR)
                        begin
                            if (can_emit)
                            begin
                                out_reg.status    <= STATUS_ERROR;
                                out_reg.req_valid <= 1'b0;
                                out_reg.req_index <= '0;
                                out_reg.packet    <= job.packet;
                                out_reg.last      <= 1'b1;
                            end
                        end
                        else
                        begin
                            pos_reg     <= IDX_W'(job.total - CNT_W'(1));
                            seen_reg    <= 1'b0;
                            missing_reg <= 1'b0;
                            emitted_reg <= 1'b0;
                            state_reg   <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN:
                begin
                    // hold the index while the output register is occupied
                    if (!emit || can_emit)
                    begin
                        if (emit)
                        begin
                            out_reg <= res;
                        end
                        seen_reg    <= seen_reg || bit_rx;
                        missing_reg <= missing_reg || !bit_rx;
                        emitted_reg <= emitted_reg || do_req;
                        if (at_end)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            pos_reg <= pos_reg - IDX_W'(1);
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign empty  = !out_valid_reg;
    assign result = out_reg;

    a_scan_has_job: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |-> job_valid)
        else $error("scan running without a job at the queue head");

    a_request_loading: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.req_valid |-> out_reg.status == STATUS_LOADING)
        else $error("request result without loading status");

    a_error_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.status == STATUS_ERROR
        |-> !out_reg.req_valid && out_reg.last)
        else $error("error result must be a lone final result");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |-> {1'b0, pos_reg} < job.total)
        else $error("scan index beyond fragment total");

endmodule

`default_nettype wire

/* rtl/fragment_reassembly_gap_requester.sv */
// Top level of the fragment reassembly gap requester.
// A begin request clears the received map and takes the packet id and fragment
// count (saturated to 64); it gives no result. An arrival marks its fragment and
// is handed as a job to a two-entry queue, so the front end keeps taking requests
// while earlier jobs are scanned. The scanner walks the map from the highest index
// down, one index per cycle; an out-of-range arrival gives a single error result.
// Scanning pauses while a result is due and the result register is not drained.
// full rises while the queue holds two jobs. Results leave through a single result
// register: empty low means a result is on the ports, pop takes it.
`default_nettype none

module fragment_reassembly_gap_requester
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic        opcode,
    input  wire logic [15:0] packet_tag,
    input  wire logic [6:0]  fragment_count,
    input  wire logic [5:0]  fragment_index,
    output logic             empty,
    input  wire logic        pop,
    output logic [1:0]       status,
    output logic             request_valid,
    output logic [5:0]       request_index,
    output logic [15:0]      request_packet,
    output logic             last_result
);
    import frgr_pkg::*;

    logic    q_full;
    logic    job_push;
    job_t    job_in;
    logic    job_valid;
    job_t    job_head;
    logic    job_pop;
    result_t result;

    frgr_front u_front
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .q_full         (q_full),
        .opcode         (opcode),
        .packet_tag     (packet_tag),
        .fragment_count (fragment_count),
        .fragment_index (fragment_index),
        .job_push       (job_push),
        .job            (job_in)
    );

    frgr_job_queue u_job_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_push),
        .job_in    (job_in),
        .full      (q_full),
        .pop       (job_pop),
        .job_valid (job_valid),
        .job_out   (job_head)
    );

    frgr_scan u_scan
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job       (job_head),
        .job_pop   (job_pop),
        .pop       (pop),
        .empty     (empty),
        .result    (result)
    );

    assign full           = q_full;
    assign status         = result.status;
    assign request_valid  = result.req_valid;
    assign request_index  = result.req_index;
    assign request_packet = result.packet;
    assign last_result    = result.last;

endmodule

`default_nettype wire

/* tb/gap_request_checker.sv */
// Checker that predicts the gap requests of each accepted request and compares them.
module gap_request_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic        full,
    input  logic        opcode,
    input  logic [15:0] packet_tag,
    input  logic [6:0]  fragment_count,
    input  logic [5:0]  fragment_index,
    input  logic        empty,
    input  logic        pop,
    input  logic [1:0]  status,
    input  logic        request_valid,
    input  logic [5:0]  request_index,
    input  logic [15:0] request_packet,
    input  logic        last_result,
    output int          mismatches,
    output int          outstanding
);
    import frgr_pkg::*;

    logic [MAP_W-1:0] rx_map;
    logic [CNT_W-1:0] frag_total;
    logic [PKT_W-1:0] cur_packet;
    result_t          expected_results[$];

    task automatic predict_gaps(input logic op, input logic [15:0] pid,
                                input logic [6:0] cnt, input logic [5:0] idx);
        result_t held;
        bit      have_held;
        bit      missing;
        bit      seen_high;
        int      pos;
        held      = '0;
        have_held = 1'b0;
        missing   = 1'b0;
        seen_high = 1'b0;
        if (op == OP_BEGIN)
        begin
            frag_total = (cnt > CNT_W'(MAX_FRAGMENTS)) ? CNT_W'(MAX_FRAGMENTS) : cnt;
            rx_map     = '0;
            cur_packet = pid;
        end
        else if ({1'b0, idx} >= frag_total)
        begin
            expected_results.push_back('{STATUS_ERROR, 1'b0, 6'd0, cur_packet, 1'b1});
        end
        else
        begin
            rx_map[idx] = 1'b1;
            // walk high to low; a gap counts once something above it has arrived, or at index 0
            for (pos = int'(frag_total) - 1; pos >= 0; pos--)
            begin
                if (rx_map[pos])
                begin
                    seen_high = 1'b1;
                end
                else
                begin
                    missing = 1'b1;
                    if (seen_high || pos == 0)
                    begin
                        if (have_held)
                            expected_results.push_back(held);
                        held      = '{STATUS_LOADING, 1'b1, 6'(pos), cur_packet, 1'b0};
                        have_held = 1'b1;
                    end
                end
            end
            if (have_held)
            begin
                held.last = 1'b1;
                expected_results.push_back(held);
            end
            else
            begin
                held = '{STATUS_READY, 1'b0, 6'd0, cur_packet, 1'b1};
                if (missing)
                    held.status = STATUS_LOADING;
                expected_results.push_back(held);
            end
        end
    endtask

    task automatic check_result();
        result_t want;
        if (expected_results.size() == 0)
        begin
            $error("unexpected result: status %0d request_valid %0d request_index %0d",
                   status, request_valid, request_index);
            mismatches++;
        end
        else
        begin
            want = expected_results.pop_front();
            if (status !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, status);
                mismatches++;
            end
            if (request_valid !== want.req_valid)
            begin
                $error("request_valid: expected %0d, got %0d", want.req_valid, request_valid);
                mismatches++;
            end
            if (request_index !== want.req_index)
            begin
                $error("request_index: expected %0d, got %0d", want.req_index, request_index);
                mismatches++;
            end
            if (request_packet !== want.packet)
            begin
                $error("request_packet: expected %0h, got %0h", want.packet, request_packet);
                mismatches++;
            end
            if (last_result !== want.last)
            begin
                $error("last_result: expected %0d, got %0d", want.last, last_result);
                mismatches++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_map      = '0;
            frag_total  = CNT_W'(1);
            cur_packet  = '0;
            mismatches  = 0;
            expected_results.delete();
            outstanding <= 0;
        end
        else
        begin
            // compare before predicting, so a stray result never meets a fresh expectation
            if (pop && !empty)
                check_result();
            if (push && !full)
                predict_gaps(opcode, packet_tag, fragment_count, fragment_index);
            outstanding <= expected_results.size();
        end
    end

endmodule

/* tb/fragment_reassembly_gap_requester_test.sv */
// Top of the testbench: clock, reset, request stimulus, result draining and verdict.
module fragment_reassembly_gap_requester_test;

    import frgr_pkg::*;

    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int DRAIN_CYCLES = 200;

    logic        clk            = 1'b0;
    logic        rst_n          = 1'b0;
    logic        push           = 1'b0;
    logic        opcode         = OP_BEGIN;
    logic [15:0] packet_tag     = '0;
    logic [6:0]  fragment_count = '0;
    logic [5:0]  fragment_index = '0;
    logic        pop            = 1'b0;
    logic        full;
    logic        empty;
    logic [1:0]  status;
    logic        request_valid;
    logic [5:0]  request_index;
    logic [15:0] request_packet;
    logic        last_result;

    int mismatches;
    int outstanding;
    int idle_pct  = 0;
    int stall_pct = 0;
    int sent      = 0;
    int cycles    = 0;

    fragment_reassembly_gap_requester i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .opcode         (opcode),
        .packet_tag     (packet_tag),
        .fragment_count (fragment_count),
        .fragment_index (fragment_index),
        .empty          (empty),
        .pop            (pop),
        .status         (status),
        .request_valid  (request_valid),
        .request_index  (request_index),
        .request_packet (request_packet),
        .last_result    (last_result)
    );

    gap_request_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .opcode         (opcode),
        .packet_tag     (packet_tag),
        .fragment_count (fragment_count),
        .fragment_index (fragment_index),
        .empty          (empty),
        .pop            (pop),
        .status         (status),
        .request_valid  (request_valid),
        .request_index  (request_index),
        .request_packet (request_packet),
        .last_result    (last_result),
        .mismatches     (mismatches),
        .outstanding    (outstanding)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        pop <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAIL fragment_reassembly_gap_requester");
            $finish;
        end
    end

    // hold push until the request is taken; leave it high for the next one
    task automatic send_req(input logic op, input logic [15:0] pid,
                            input logic [6:0] cnt, input logic [5:0] idx);
        while ($urandom_range(99) < idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push           <= 1'b1;
        opcode         <= op;
        packet_tag     <= pid;
        fragment_count <= cnt;
        fragment_index <= idx;
        @(posedge clk);
        while (full)
            @(posedge clk);
        sent++;
    endtask

    task automatic send_arrival(input logic [5:0] idx);
        send_req(OP_ARRIVE, 16'($urandom), 7'($urandom), idx);
    endtask

    task automatic random_packet();
        int         roll;
        int         eff;
        int         n_arr;
        int         k;
        logic [6:0] cnt;
        roll = $urandom_range(99);
        if (roll < 10)
        begin
            // stray arrival against whatever packet is open
            send_arrival(6'($urandom));
        end
        else
        begin
            roll = $urandom_range(99);
            if (roll < 60)
                cnt = 7'($urandom_range(1, 12));
            else if (roll < 85)
                cnt = 7'($urandom_range(13, 64));
            else if (roll < 93)
                cnt = 7'($urandom_range(65, 127));
            else
                cnt = 7'd0;
            eff = (cnt > 7'(MAX_FRAGMENTS)) ? MAX_FRAGMENTS : int'(cnt);
            send_req(OP_BEGIN, 16'($urandom), cnt, 6'($urandom));
            n_arr = $urandom_range(1, eff + 2);
            for (k = 0; k < n_arr; k++)
            begin
                if (eff == 0 || $urandom_range(99) < 12)
                    send_arrival(6'($urandom));
                else
                    send_arrival(6'($urandom_range(0, eff - 1)));
            end
        end
    endtask

    task automatic run_phase(input int idle, input int stall, input int quota);
        int start;
        start     = sent;
        idle_pct  = idle;
        stall_pct = stall;
        while (sent - start < quota)
            random_packet();
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // straight after reset the packet has a single fragment
        send_arrival(6'd0);
        send_arrival(6'd1);
        // zero count: every arrival is out of range
        send_req(OP_BEGIN, 16'hFFFF, 7'd0, 6'd63);
        send_arrival(6'd0);
        // count saturates at the maximum
        send_req(OP_BEGIN, 16'h1234, 7'd127, 6'd0);
        send_arrival(6'd63);
        send_arrival(6'd63);
        send_arrival(6'd0);
        // only the lowest fragment in: loading with nothing to ask for
        send_req(OP_BEGIN, 16'h0000, 7'd64, 6'd0);
        send_arrival(6'd0);
        send_req(OP_BEGIN, 16'hA5A5, 7'd4, 6'd0);
        send_arrival(6'd3);
        send_arrival(6'd2);
        send_arrival(6'd1);
        send_arrival(6'd0);
        send_arrival(6'd0);
        send_arrival(6'd4);
        send_arrival(6'd63);
        send_req(OP_BEGIN, 16'h5A5A, 7'd1, 6'd0);
        send_arrival(6'd1);
        send_arrival(6'd0);
        send_req(OP_BEGIN, 16'h8000, 7'd65, 6'd0);
        send_arrival(6'd42);

        run_phase(0, 0, 125);
        run_phase(61, 0, 125);
        run_phase(0, 61, 125);
        run_phase(38, 38, 125);

        push <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("PASS fragment_reassembly_gap_requester");
        else
            $display("FAIL fragment_reassembly_gap_requester");
        $finish;
    end

endmodule
